// ----- hw/rtl/park_ang_damage_index_unit_defines.svh -----
// Assertion macros for the Park-Ang damage index unit.
// Used by the port checker; no other dependencies.
`ifndef PARK_ANG_DAMAGE_INDEX_UNIT_DEFINES_SVH
`define PARK_ANG_DAMAGE_INDEX_UNIT_DEFINES_SVH

// Concurrent assertion, disabled while reset is high.
`define PAIDX_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Concurrent assertion that also checks through reset.
`define PAIDX_ASSERT_RST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// ----- hw/rtl/paidx_pkg.sv -----
// Shared types, constants and helper functions of the damage index unit.
// No dependencies; the modules use it by scoped names.
package paidx_pkg;

   localparam int unsigned DATA_W    = 32;
   localparam int unsigned CFG_W     = 31;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned MCAND_W   = 63;
   localparam int unsigned MPLIER_W  = 33;
   localparam int unsigned PROD_W    = MCAND_W + MPLIER_W;
   localparam int unsigned DIVISOR_W = 33;
   localparam int unsigned QUO_W     = 63;
   localparam int unsigned STEP_W    = 7;

   localparam logic [STEP_W-1:0] MUL_STEPS         = 7'd33;
   localparam logic [STEP_W-1:0] DIV_STEPS_PLASTIC = 7'd63;
   localparam logic [STEP_W-1:0] DIV_STEPS_WEIGHT  = 7'd93;
   localparam logic [STEP_W-1:0] DIV_STEPS_DAMAGE  = 7'd79;

   localparam logic [QUO_W-1:0]    CAP_WIDE   = {1'b1, 62'd0};
   localparam logic [QUO_W-1:0]    CAP_DAMAGE = {32'd0, {31{1'b1}}};
   localparam logic [MPLIER_W-1:0] Q_ONE      = 33'h0_0001_0000;

   localparam logic [CFG_W-1:0] CFG_ONE          = 31'd1;
   localparam logic [CFG_W-1:0] ULT_DEF_RESET    = 31'd65536;
   localparam logic [CFG_W-1:0] ENERGY_WT_RESET  = 31'd6554;
   localparam logic [CFG_W-1:0] YIELD_STR_RESET  = 31'd65536;

   typedef enum logic [1:0] {
      CMD_TRIAL        = 2'd0,
      CMD_COMMIT       = 2'd1,
      CMD_REVERT_LAST  = 2'd2,
      CMD_REVERT_START = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ULT_DEF   = 2'd0,
      CSR_ENERGY_WT = 2'd1,
      CSR_YIELD_STR = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CFG_W-1:0] ult_def;
      logic [CFG_W-1:0] energy_wt;
      logic [CFG_W-1:0] yield_str;
   } cfg_type;

   typedef struct packed {
      logic [DATA_W-1:0] frc;
      logic [DATA_W-1:0] defo;
      logic [DATA_W-1:0] energy;
      logic [CFG_W-1:0]  maxdef;
      logic [CFG_W-1:0]  dmg;
   } rec_type;

   typedef struct packed {
      logic                 start;
      logic                 div;
      logic [MCAND_W-1:0]   mcand;
      logic [MPLIER_W-1:0]  mplier;
      logic [DIVISOR_W-1:0] divisor;
      logic [STEP_W-1:0]    nbits;
      logic [QUO_W-1:0]     cap;
   } md_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] prod;
      logic [QUO_W-1:0]  quo;
   } md_rsp_type;

   function automatic md_req_type mul_req(input logic [MCAND_W-1:0] mcand,
                                          input logic [MPLIER_W-1:0] mplier);
      md_req_type r;
      r         = '0;
      r.start   = 1'b1;
      r.div     = 1'b0;
      r.mcand   = mcand;
      r.mplier  = mplier;
      r.nbits   = MUL_STEPS;
      return r;
   endfunction

   function automatic md_req_type div_req(input logic [DIVISOR_W-1:0] divisor,
                                          input logic [STEP_W-1:0] nbits,
                                          input logic [QUO_W-1:0] cap);
      md_req_type r;
      r         = '0;
      r.start   = 1'b1;
      r.div     = 1'b1;
      r.divisor = divisor;
      r.nbits   = nbits;
      r.cap     = cap;
      return r;
   endfunction

endpackage

// ----- hw/rtl/paidx_ifs.sv -----
// Valid/ready channel interfaces for the damage index unit: request and result.
// Depends on nothing.
interface paidx_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         cmd;
   logic signed [31:0] deformation;
   logic signed [31:0] force_req;
   logic signed [31:0] unloading_stiffness;

   modport source (output valid, cmd, deformation, force_req, unloading_stiffness,
                   input ready);
   modport sink   (input valid, cmd, deformation, force_req, unloading_stiffness,
                   output ready);
endinterface

interface paidx_rsp_if;
   logic               valid;
   logic               ready;
   logic [30:0]        damage;
   logic signed [31:0] energy;
   logic [30:0]        max_deformation;
   logic               status;

   modport source (output valid, damage, energy, max_deformation, status,
                   input ready);
   modport sink   (input valid, damage, energy, max_deformation, status,
                   output ready);
endinterface

// ----- hw/rtl/park_ang_damage_index_unit.sv -----
// Commit, revert and rejected trial transfers pass through S_FIN into the result register;
// a trial step runs its multiplies and its plastic, weight and damage divides on the shared
// bit-serial multiply/divide unit, each with a handoff, and how long it takes depends on
// whether the plastic and damage divides are needed.
// Throughput: one item in flight; the next is accepted once the result is registered.
// Reset (synchronous): clears all records and the result valid flag, restores registers.
module park_ang_damage_index_unit (
   input  logic                                clock,
   input  logic                                reset,
   paidx_req_if.sink                           req_bus,
   paidx_rsp_if.source                         rsp_bus,
   input  logic                                csr_we,
   input  logic [paidx_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [paidx_pkg::CFG_W-1:0]         csr_wdata
);

   logic [paidx_pkg::CFG_W-1:0] ult_def_ff, ult_def_in;
   logic [paidx_pkg::CFG_W-1:0] energy_wt_ff, energy_wt_in;
   logic [paidx_pkg::CFG_W-1:0] yield_str_ff, yield_str_in;

   paidx_pkg::cfg_type    cfg;
   paidx_pkg::md_req_type md_req;
   paidx_pkg::md_rsp_type md_rsp;

   always_comb begin
      ult_def_in   = ult_def_ff;
      energy_wt_in = energy_wt_ff;
      yield_str_in = yield_str_ff;
      if (csr_we) begin
         case (csr_index)
            paidx_pkg::CSR_ULT_DEF:   ult_def_in   = csr_wdata;
            paidx_pkg::CSR_ENERGY_WT: energy_wt_in = csr_wdata;
            paidx_pkg::CSR_YIELD_STR: yield_str_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ult_def_ff   <= paidx_pkg::ULT_DEF_RESET;
         energy_wt_ff <= paidx_pkg::ENERGY_WT_RESET;
         yield_str_ff <= paidx_pkg::YIELD_STR_RESET;
      end else begin
         ult_def_ff   <= ult_def_in;
         energy_wt_ff <= energy_wt_in;
         yield_str_ff <= yield_str_in;
      end
   end

   // zero acts as one LSB
   assign cfg.ult_def   = (ult_def_ff == '0)   ? paidx_pkg::CFG_ONE : ult_def_ff;
   assign cfg.energy_wt = (energy_wt_ff == '0) ? paidx_pkg::CFG_ONE : energy_wt_ff;
   assign cfg.yield_str = (yield_str_ff == '0) ? paidx_pkg::CFG_ONE : yield_str_ff;

   paidx_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .md_req  (md_req),
      .md_rsp  (md_rsp)
   );

   paidx_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .md_rsp (md_rsp)
   );

endmodule

// ----- hw/rtl/paidx_muldiv.sv -----
// Shared bit-serial multiply and restoring divide unit, one bit per cycle.
// Depends on paidx_pkg. The divide works on the product left by the last multiply.
module paidx_muldiv (
   input  logic                   clock,
   input  logic                   reset,
   input  paidx_pkg::md_req_type  md_req,
   output paidx_pkg::md_rsp_type  md_rsp
);

   typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} md_state_type;

   md_state_type state_ff, state_in;
   logic done_ff, done_in;
   logic [paidx_pkg::STEP_W-1:0] cnt_ff, cnt_in;

   logic [paidx_pkg::MCAND_W-1:0]   mcand_ff, mcand_in;
   logic [paidx_pkg::MPLIER_W-1:0]  mplier_ff, mplier_in;
   logic [paidx_pkg::DIVISOR_W-1:0] divisor_ff, divisor_in;
   logic [paidx_pkg::QUO_W-1:0]     cap_ff, cap_in;
   logic [paidx_pkg::PROD_W-1:0]    prod_ff, prod_in;
   logic [paidx_pkg::DIVISOR_W-1:0] rem_ff, rem_in;
   logic [paidx_pkg::QUO_W:0]       quo_ff, quo_in;
   logic ovf_ff, ovf_in;

   logic [paidx_pkg::PROD_W-1:0]    mul_sum;
   logic [paidx_pkg::DIVISOR_W:0]   rem_shift;
   logic [paidx_pkg::DIVISOR_W+1:0] rem_diff;
   logic                            quo_bit;
   logic [paidx_pkg::QUO_W-1:0]     quo_sat;

   assign mul_sum = {prod_ff[paidx_pkg::PROD_W-2:0], 1'b0}
                  + (mplier_ff[paidx_pkg::MPLIER_W-1]
                     ? {{paidx_pkg::MPLIER_W{1'b0}}, mcand_ff}
                     : {paidx_pkg::PROD_W{1'b0}});
   assign rem_shift = {rem_ff, prod_ff[cnt_ff]};
   assign rem_diff  = {1'b0, rem_shift} - {2'b00, divisor_ff};
   assign quo_bit   = ~rem_diff[paidx_pkg::DIVISOR_W+1];
   assign quo_sat   = (ovf_ff || (quo_ff > {1'b0, cap_ff})) ? cap_ff
                    : quo_ff[paidx_pkg::QUO_W-1:0];

   always_comb begin
      state_in   = state_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      mcand_in   = mcand_ff;
      mplier_in  = mplier_ff;
      divisor_in = divisor_ff;
      cap_in     = cap_ff;
      prod_in    = prod_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      ovf_in     = ovf_ff;
      case (state_ff)
         MD_IDLE: begin
            if (md_req.start) begin
               mcand_in   = md_req.mcand;
               mplier_in  = md_req.mplier;
               divisor_in = md_req.divisor;
               cap_in     = md_req.cap;
               cnt_in     = md_req.nbits - 7'd1;
               if (md_req.div) begin
                  rem_in   = '0;
                  quo_in   = '0;
                  ovf_in   = 1'b0;
                  state_in = MD_DIV;
               end else begin
                  prod_in  = '0;
                  state_in = MD_MUL;
               end
            end
         end
         MD_MUL: begin
            prod_in   = mul_sum;
            mplier_in = {mplier_ff[paidx_pkg::MPLIER_W-2:0], 1'b0};
         end
         MD_DIV: begin
            rem_in = quo_bit ? rem_diff[paidx_pkg::DIVISOR_W-1:0]
                             : rem_shift[paidx_pkg::DIVISOR_W-1:0];
            quo_in = {quo_ff[paidx_pkg::QUO_W-1:0], quo_bit};
            ovf_in = ovf_ff | quo_ff[paidx_pkg::QUO_W];
         end
         default: begin
            state_in = MD_IDLE;
         end
      endcase
      if (state_ff == MD_MUL || state_ff == MD_DIV) begin
         if (cnt_ff == '0) begin
            state_in = MD_IDLE;
            done_in  = 1'b1;
         end else begin
            cnt_in = cnt_ff - 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff   <= mcand_in;
      mplier_ff  <= mplier_in;
      divisor_ff <= divisor_in;
      cap_ff     <= cap_in;
      prod_ff    <= prod_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      ovf_ff     <= ovf_in;
   end

   assign md_rsp.done = done_ff;
   assign md_rsp.prod = prod_ff;
   assign md_rsp.quo  = quo_sat;

endmodule

// ----- hw/rtl/paidx_seq.sv -----
// Command sequencer: trial/commit/revert records, step control of the shared
// multiply/divide unit, and the result register. Depends on paidx_pkg, paidx_ifs.
module paidx_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  paidx_pkg::cfg_type    cfg,
   paidx_req_if.sink             req_bus,
   paidx_rsp_if.source           rsp_bus,
   output paidx_pkg::md_req_type md_req,
   input  paidx_pkg::md_rsp_type md_rsp
);

   typedef enum logic [3:0] {
      S_IDLE, S_PREP, S_ENERGY, S_SQF, S_PLAS, S_WSTART,
      S_WMUL, S_WDIV, S_DMUL, S_DDIV, S_FIN
   } seq_state_type;

   seq_state_type state_ff, state_in;
   paidx_pkg::rec_type trial_ff, trial_in, com_ff, com_in, prev_ff, prev_in;
   paidx_pkg::md_req_type md_req_ff, md_req_in;
   logic status_ff, status_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [30:0] rsp_dmg_ff, rsp_dmg_in;
   logic [31:0] rsp_energy_ff, rsp_energy_in;
   logic [30:0] rsp_maxdef_ff, rsp_maxdef_in;
   logic rsp_status_ff, rsp_status_in;

   logic [31:0] td_ff, td_in, tf_ff, tf_in, tk_ff, tk_in;
   logic [31:0] te_ff, te_in;
   logic [63:0] pe_ff, pe_in;
   logic [30:0] tmax_ff, tmax_in;
   logic neg_e_ff, neg_e_in;

   logic [32:0] s_sum, d_diff, s_mag, d_mag;
   logic [47:0] inc;
   logic [49:0] ce_ext, te_wide;
   logic [31:0] te_sat;
   logic [31:0] f_mag, d_abs;
   logic [30:0] absd_sat, tmax_new;
   logic [63:0] pe_mag, w_signed, sum;
   logic [30:0] q_dmg, dmg_new;
   paidx_pkg::rec_type trial_new;

   function automatic logic [49:0] pe_neg_energy(input logic [49:0] base,
                                                 input logic [47:0] step,
                                                 input logic        neg);
      logic [49:0] ext;
      ext = {2'b00, step};
      return neg ? (base - ext) : (base + ext);
   endfunction

   assign s_sum  = {tf_ff[31], tf_ff} + {com_ff.frc[31], com_ff.frc};
   assign d_diff = {td_ff[31], td_ff} - {com_ff.defo[31], com_ff.defo};
   assign s_mag  = s_sum[32] ? (33'd0 - s_sum) : s_sum;
   assign d_mag  = d_diff[32] ? (33'd0 - d_diff) : d_diff;

   assign inc     = md_rsp.prod[64:17];
   assign ce_ext  = {{18{com_ff.energy[31]}}, com_ff.energy};
   assign te_wide = pe_neg_energy(ce_ext, inc, neg_e_ff);
   assign te_sat  = (te_wide[49:31] == {19{te_wide[49]}}) ? te_wide[31:0]
                  : (te_wide[49] ? 32'h8000_0000 : 32'h7FFF_FFFF);

   assign f_mag    = tf_ff[31] ? (32'd0 - tf_ff) : tf_ff;
   assign d_abs    = td_ff[31] ? (32'd0 - td_ff) : td_ff;
   assign absd_sat = d_abs[31] ? 31'h7FFF_FFFF : d_abs[30:0];
   assign tmax_new = (absd_sat > com_ff.maxdef) ? absd_sat : com_ff.maxdef;
   assign pe_mag   = pe_ff[63] ? (64'd0 - pe_ff) : pe_ff;

   assign w_signed = pe_ff[63] ? (64'd0 - {1'b0, md_rsp.quo}) : {1'b0, md_rsp.quo};
   assign sum      = {33'd0, tmax_ff} + w_signed;
   assign q_dmg    = md_rsp.quo[30:0];
   assign dmg_new  = (q_dmg > com_ff.dmg) ? q_dmg : com_ff.dmg;

   always_comb begin
      trial_new.frc    = tf_ff;
      trial_new.defo   = td_ff;
      trial_new.energy = te_ff;
      trial_new.maxdef = tmax_ff;
      trial_new.dmg    = (state_ff == S_DDIV) ? dmg_new : com_ff.dmg;
   end

   always_comb begin
      state_in        = state_ff;
      trial_in        = trial_ff;
      com_in          = com_ff;
      prev_in         = prev_ff;
      md_req_in       = md_req_ff;
      md_req_in.start = 1'b0;
      status_in       = status_ff;
      td_in           = td_ff;
      tf_in           = tf_ff;
      tk_in           = tk_ff;
      neg_e_in        = neg_e_ff;
      te_in           = te_ff;
      pe_in           = pe_ff;
      tmax_in         = tmax_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_bus.ready;
      rsp_dmg_in      = rsp_dmg_ff;
      rsp_energy_in   = rsp_energy_ff;
      rsp_maxdef_in   = rsp_maxdef_ff;
      rsp_status_in   = rsp_status_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               td_in     = req_bus.deformation;
               tf_in     = req_bus.force_req;
               tk_in     = req_bus.unloading_stiffness;
               status_in = 1'b0;
               state_in  = S_FIN;
               case (paidx_pkg::cmd_type'(req_bus.cmd))
                  paidx_pkg::CMD_TRIAL: begin
                     if (req_bus.unloading_stiffness[31]) begin
                        status_in = 1'b1;
                     end else begin
                        state_in = S_PREP;
                     end
                  end
                  paidx_pkg::CMD_COMMIT: begin
                     prev_in = com_ff;
                     com_in  = trial_ff;
                  end
                  paidx_pkg::CMD_REVERT_LAST: begin
                     com_in = prev_ff;
                  end
                  paidx_pkg::CMD_REVERT_START: begin
                     trial_in = '0;
                     com_in   = '0;
                     prev_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_PREP: begin
            md_req_in = paidx_pkg::mul_req({30'd0, s_mag}, d_mag);
            neg_e_in  = s_sum[32] ^ d_diff[32];
            state_in  = S_ENERGY;
         end
         S_ENERGY: begin
            if (md_rsp.done) begin
               te_in = te_sat;
               pe_in = {{32{te_sat[31]}}, te_sat};
               if (tk_ff == '0) begin
                  state_in = S_WSTART;
               end else begin
                  md_req_in = paidx_pkg::mul_req({31'd0, f_mag}, {1'b0, f_mag});
                  state_in  = S_SQF;
               end
            end
         end
         S_SQF: begin
            if (md_rsp.done) begin
               md_req_in = paidx_pkg::div_req({tk_ff, 1'b0},
                                              paidx_pkg::DIV_STEPS_PLASTIC,
                                              paidx_pkg::CAP_WIDE);
               state_in  = S_PLAS;
            end
         end
         S_PLAS: begin
            if (md_rsp.done) begin
               pe_in    = {{32{te_ff[31]}}, te_ff} - {1'b0, md_rsp.quo};
               state_in = S_WSTART;
            end
         end
         S_WSTART: begin
            md_req_in = paidx_pkg::mul_req(pe_mag[62:0], {2'b00, cfg.energy_wt});
            tmax_in   = tmax_new;
            state_in  = S_WMUL;
         end
         S_WMUL: begin
            if (md_rsp.done) begin
               md_req_in = paidx_pkg::div_req({2'b00, cfg.yield_str},
                                              paidx_pkg::DIV_STEPS_WEIGHT,
                                              paidx_pkg::CAP_WIDE);
               state_in  = S_WDIV;
            end
         end
         S_WDIV: begin
            if (md_rsp.done) begin
               if (sum[63]) begin
                  trial_in = trial_new;
                  state_in = S_FIN;
               end else begin
                  md_req_in = paidx_pkg::mul_req(sum[62:0], paidx_pkg::Q_ONE);
                  state_in  = S_DMUL;
               end
            end
         end
         S_DMUL: begin
            if (md_rsp.done) begin
               md_req_in = paidx_pkg::div_req({2'b00, cfg.ult_def},
                                              paidx_pkg::DIV_STEPS_DAMAGE,
                                              paidx_pkg::CAP_DAMAGE);
               state_in  = S_DDIV;
            end
         end
         S_DDIV: begin
            if (md_rsp.done) begin
               trial_in = trial_new;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_dmg_in    = trial_ff.dmg;
               rsp_energy_in = trial_ff.energy;
               rsp_maxdef_in = trial_ff.maxdef;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         trial_ff     <= '0;
         com_ff       <= '0;
         prev_ff      <= '0;
         md_req_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         trial_ff     <= trial_in;
         com_ff       <= com_in;
         prev_ff      <= prev_in;
         md_req_ff    <= md_req_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      rsp_dmg_ff    <= rsp_dmg_in;
      rsp_energy_ff <= rsp_energy_in;
      rsp_maxdef_ff <= rsp_maxdef_in;
      rsp_status_ff <= rsp_status_in;
      td_ff         <= td_in;
      tf_ff         <= tf_in;
      tk_ff         <= tk_in;
      neg_e_ff      <= neg_e_in;
      te_ff         <= te_in;
      pe_ff         <= pe_in;
      tmax_ff       <= tmax_in;
   end

   assign req_bus.ready           = (state_ff == S_IDLE);
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.damage          = rsp_dmg_ff;
   assign rsp_bus.energy          = rsp_energy_ff;
   assign rsp_bus.max_deformation = rsp_maxdef_ff;
   assign rsp_bus.status          = rsp_status_ff;
   assign md_req                  = md_req_ff;

endmodule

// ----- hw/rtl/paidx_chk.sv -----
// Port-level checker for the damage index unit, bound to the top level.
// Depends on paidx_pkg and park_ang_damage_index_unit_defines.svh.
`include "park_ang_damage_index_unit_defines.svh"

module paidx_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_cmd,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [30:0] rsp_damage,
   input logic [31:0] rsp_energy,
   input logic [30:0] rsp_max_deformation,
   input logic        rsp_status
);

   `PAIDX_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_damage) && $stable(rsp_energy) && $stable(rsp_max_deformation) && $stable(rsp_status), "result changed while stalled")

   `PAIDX_ASSERT(a_busy_after_transfer, clock, reset, req_valid && req_ready |=> !req_ready, "request taken while an item is in work")

   `PAIDX_ASSERT(a_clear_result, clock, reset, req_valid && req_ready && req_cmd == paidx_pkg::CMD_REVERT_START ##1 (!rsp_valid || rsp_ready) |=> rsp_valid && rsp_damage == '0 && rsp_energy == '0 && rsp_max_deformation == '0 && !rsp_status, "revert to start did not give a cleared result")

   `PAIDX_ASSERT_RST(a_reset_state, clock, reset |=> !rsp_valid && req_ready, "unit not idle after reset")

endmodule

bind park_ang_damage_index_unit paidx_chk u_paidx_chk (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_bus.valid),
   .req_ready           (req_bus.ready),
   .req_cmd             (req_bus.cmd),
   .rsp_valid           (rsp_bus.valid),
   .rsp_ready           (rsp_bus.ready),
   .rsp_damage          (rsp_bus.damage),
   .rsp_energy          (rsp_bus.energy),
   .rsp_max_deformation (rsp_bus.max_deformation),
   .rsp_status          (rsp_bus.status)
);
